@@ rtl/sat_pkg.sv @@
package sat_pkg;

  localparam int unsigned MaxArgsDefault = 255;
  localparam int unsigned CountMax       = 255;

  // Characters with a special role in the scanner
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChReturn    = 8'h0d;
  localparam logic [7:0] ChFormFeed  = 8'h0c;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;

  typedef enum logic [3:0] {
    MODE_SKIP = 4'b0001,
    MODE_ARG  = 4'b0010,
    MODE_SQ   = 4'b0100,
    MODE_DQ   = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t  scan_mode;
    logic        escape_pending;
    logic [7:0]  args_closed;
  } scan_state_t;

  localparam scan_state_t ScanStateReset = '{
    scan_mode:      MODE_SKIP,
    escape_pending: 1'b0,
    args_closed:    8'd0
  };

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } cmd_beat_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic [7:0] arg_index;
    logic       arg_end;
    logic       command_end;
    logic [7:0] arg_count;
  } tok_beat_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChNewline) ||
           (c == ChReturn) || (c == ChFormFeed);
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v, input logic [7:0] limit);
    return (v < limit) ? v + 8'd1 : limit;
  endfunction

endpackage

@@ rtl/sat_cmd_if.sv @@
interface sat_cmd_if;
  import sat_pkg::*;

  logic      valid;
  logic      ready;
  cmd_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sat_tok_if.sv @@
interface sat_tok_if;
  import sat_pkg::*;

  logic      valid;
  logic      ready;
  tok_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sat_decode.sv @@
module sat_decode #(
  parameter logic [7:0] COUNT_LIMIT = 8'd255
) (
  input  sat_pkg::scan_state_t state,
  input  sat_pkg::cmd_beat_t   beat,
  output sat_pkg::scan_state_t state_next,
  output sat_pkg::tok_beat_t   result
);
  import sat_pkg::*;

  logic        keep;
  logic        aend;
  scan_mode_t  mode_n;
  logic        esc_n;
  logic [7:0]  closed_n;
  logic [7:0]  c;

  assign c = beat.char_in;

  always_comb begin
    keep     = 1'b0;
    aend     = 1'b0;
    mode_n   = state.scan_mode;
    esc_n    = 1'b0;
    closed_n = state.args_closed;

    priority if (state.escape_pending) begin
      keep = 1'b1;
    end else if (is_blank(c)) begin
      if (state.scan_mode == MODE_ARG) begin
        aend     = 1'b1;
        closed_n = sat_inc(state.args_closed, COUNT_LIMIT);
        mode_n   = MODE_SKIP;
      end else if (state.scan_mode != MODE_SKIP) begin
        keep = 1'b1;
      end
    end else if (c == ChBackslash) begin
      if (state.scan_mode == MODE_SQ) begin
        keep = 1'b1;
      end else begin
        if (state.scan_mode == MODE_SKIP) mode_n = MODE_ARG;
        // a backslash on the final byte has nothing to escape
        if (beat.last_char) keep = 1'b1;
        else esc_n = 1'b1;
      end
    end else if (c == ChDquote) begin
      if (state.scan_mode == MODE_DQ) mode_n = MODE_ARG;
      else if (state.scan_mode != MODE_SQ) mode_n = MODE_DQ;
      else keep = 1'b1;
    end else if (c == ChSquote) begin
      if (state.scan_mode == MODE_SQ) mode_n = MODE_ARG;
      else if (state.scan_mode != MODE_DQ) mode_n = MODE_SQ;
      else keep = 1'b1;
    end else begin
      keep = 1'b1;
      if (state.scan_mode == MODE_SKIP) mode_n = MODE_ARG;
    end

    // close any open argument on the final byte
    if (beat.last_char && (mode_n != MODE_SKIP)) begin
      aend     = 1'b1;
      closed_n = sat_inc(closed_n, COUNT_LIMIT);
    end
  end

  always_comb begin
    if (beat.last_char) begin
      state_next = ScanStateReset;
    end else begin
      state_next.scan_mode      = mode_n;
      state_next.escape_pending = esc_n;
      state_next.args_closed    = closed_n;
    end
  end

  assign result.char_valid  = keep;
  assign result.char_out    = keep ? c : 8'd0;
  assign result.arg_index   = (keep || aend) ? state.args_closed : 8'd0;
  assign result.arg_end     = aend;
  assign result.command_end = beat.last_char;
  assign result.arg_count   = beat.last_char ? closed_n : 8'd0;

endmodule

@@ rtl/shell_argument_tokenizer_unit.sv @@
// Shell argument tokenizer.
//
// cmd (sink): one command-line byte per beat, char_in plus last_char on the
//   final byte of a command. Bytes are split into white-space separated
//   arguments with Bourne-style quoting and backslash escapes.
// tok (source): one result beat per cmd beat, in order: the kept character
//   and its argument index, an argument-end flag, and on the final byte
//   command_end with the argument count (saturating at min(MAX_ARGS, 255)).
//
// Path: cmd beats are captured in the input register, then pass through the
//   scan logic into the result register. Throughput: one byte per cycle while
//   tok is taken; the scan state loops through one register and the decode logic.
// Reset (rst, synchronous): both stages empty, scanner between arguments, no
//   escape pending, argument count zero. The scanner also returns to this
//   state by itself after the final byte of each command.
// Stall: when tok is not taken the result register holds its beat, the input
//   register fills and holds behind it, and cmd.ready drops; no beat is lost.
module shell_argument_tokenizer_unit #(
  parameter int unsigned MAX_ARGS = sat_pkg::MaxArgsDefault
) (
  input logic   clk,
  input logic   rst,
  sat_cmd_if.sink   cmd,
  sat_tok_if.source tok
);
  import sat_pkg::*;

  localparam logic [7:0] COUNT_LIMIT =
    (MAX_ARGS < CountMax) ? 8'(MAX_ARGS) : 8'(CountMax);

  // input stage
  logic        s1_valid;
  cmd_beat_t   s1_beat;

  // scanner state and decode results
  scan_state_t state;
  scan_state_t state_next;
  tok_beat_t   result;

  logic out_free;
  logic s1_free;
  logic s1_fire;

  // result register can take a beat when empty or being drained
  assign out_free  = !tok.valid || tok.ready;
  assign s1_fire   = s1_valid && out_free;
  assign s1_free   = !s1_valid || out_free;
  assign cmd.ready = s1_free;

  // hold the byte until the result register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && s1_free) begin
      s1_beat <= cmd.data;
    end
  end

  sat_decode #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_decode (
    .state      (state),
    .beat       (s1_beat),
    .state_next (state_next),
    .result     (result)
  );

  // advance the scanner only when a byte moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ScanStateReset;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (out_free) begin
      tok.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      tok.data <= result;
    end
  end

endmodule

@@ rtl/sat_checker.sv @@
module sat_checker (
  input logic       clk,
  input logic       rst,
  input logic       tok_valid,
  input logic       tok_ready,
  input logic       char_valid,
  input logic [7:0] char_out,
  input logic [7:0] arg_index,
  input logic       arg_end,
  input logic       command_end,
  input logic [7:0] arg_count
);

  // a stalled result beat stays offered
  a_tok_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid)
    else $error("tok beat dropped while stalled");

  // no result may appear right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !tok_valid)
    else $error("tok valid right after reset");

  a_count_only_at_end: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !command_end |-> arg_count == 8'd0)
    else $error("arg_count nonzero before command end");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !char_valid |-> char_out == 8'd0)
    else $error("char_out set without a kept character");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !char_valid && !arg_end |-> arg_index == 8'd0)
    else $error("arg_index set with no character and no argument end");

endmodule

bind shell_argument_tokenizer_unit sat_checker u_sat_checker (
  .clk         (clk),
  .rst         (rst),
  .tok_valid   (tok.valid),
  .tok_ready   (tok.ready),
  .char_valid  (tok.data.char_valid),
  .char_out    (tok.data.char_out),
  .arg_index   (tok.data.arg_index),
  .arg_end     (tok.data.arg_end),
  .command_end (tok.data.command_end),
  .arg_count   (tok.data.arg_count)
);
